[src/hdt_pkg.sv]
`default_nettype none

package hdt_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Register reset values.
  localparam logic [18:0] NOTCH_WIDTH_RST = 19'd6862;
  localparam logic [15:0] END_LIMIT_RST   = 16'd255;
  localparam logic [7:0]  VERNIER_RST     = 8'd1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Shared multiplier: 32 x 19 bits.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Iterative divider geometry.
  localparam int DIV_NUM_W     = 52;
  localparam int DIV_DEN_W     = 22;
  localparam int DIV_STEP_BITS = 2;

  // Progressive window: 0.15 = 3/20 on a Q0.16 fraction, rounded to nearest.
  // round(m / D) = (2m + D) / 2D with D = 20 * 2^16, and 2D = 5 * 2^19, so the
  // division is a shift by 19 followed by a reciprocal multiplication by 1/5.
  localparam int                    PROG_SUM_W = 51;
  localparam logic [PROG_SUM_W-1:0] PROG_BIAS  = PROG_SUM_W'(1310720);
  // floor(n / 5) = (n * DIV5_RECIP) >> 34 for any 32 bit n.
  localparam logic [31:0]           DIV5_RECIP = 32'hCCCC_CCCD;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOTCH_WIDTH = 3'd0,
    REG_HYSTERESIS  = 3'd1,
    REG_PROGRESSIVE = 3'd2,
    REG_START_LIMIT = 3'd3,
    REG_END_LIMIT   = 3'd4,
    REG_VERNIER     = 3'd5,
    REG_SENSOR_CCW  = 3'd6
  } hdt_reg_e;

  // Event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_INCREASE = 3'd1,
    EV_DECREASE = 3'd2,
    EV_POS_LIM  = 3'd3,
    EV_NEG_LIM  = 3'd4
  } hdt_event_e;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_PSUM,
    S_PRECIP,
    S_CMP,
    S_SDIV,
    S_SWAIT,
    S_SMUL,
    S_SAT,
    S_UPD
  } hdt_state_e;

  // Input word.
  typedef struct packed {
    logic               command;
    logic signed [31:0] raw_angle;
    logic [15:0]        load_position;
  } hdt_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]         event_code;
    logic [15:0]        position;
    logic signed [31:0] attract_angle_out;
    logic               at_limit_flag;
    logic               was_at_limit_flag;
  } hdt_out_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    logic               origin;
    logic               neg;
    logic signed [31:0] angle;
    logic [31:0]        mag;
    logic [15:0]        load;
  } hdt_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [18:0] notch_width;
    logic [15:0] hysteresis_fraction;
    logic        progressive_mode;
    logic [15:0] start_limit;
    logic [15:0] end_limit;
    logic [7:0]  vernier_factor;
    logic        sensor_ccw;
  } hdt_cfg_t;

  // Divider request and response.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } hdt_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } hdt_div_rsp_t;

endpackage

`default_nettype wire

[src/hdt_stream_if.sv]
`default_nettype none

// Valid/ready channel carrying one word per handshake.
interface hdt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/hdt_div.sv]
`default_nettype none

// Restoring divider, DIV_STEP_BITS quotient bits per cycle.
module hdt_div
  import hdt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire hdt_div_req_t req,
  output hdt_div_rsp_t      rsp
);

  localparam int ITERS = DIV_NUM_W / DIV_STEP_BITS;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [DIV_NUM_W-1:0] nq;
  logic [DIV_NUM_W-1:0] nq_next;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W:0]   rem_next;
  logic [DIV_DEN_W-1:0] den;
  logic [CNT_W-1:0]     count;
  logic                 busy;
  logic                 done;

  // A few shift-subtract steps; quotient bits enter at the bottom of nq.
  always_comb begin
    rem_next = rem;
    nq_next  = nq;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      rem_next = {rem_next[DIV_DEN_W-1:0], nq_next[DIV_NUM_W-1]};
      nq_next  = {nq_next[DIV_NUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next   = rem_next - {1'b0, den};
        nq_next[0] = 1'b1;
      end
    end
  end

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(ITERS);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      nq  <= req.numer;
      rem <= '0;
      den <= req.denom;
    end else if (busy) begin
      nq  <= nq_next;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = nq;

endmodule

`default_nettype wire

[src/hdt_front.sv]
`default_nettype none

// Front end: configuration registers, input acceptance and classification.
module hdt_front
  import hdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  hdt_stream_if.sink                 samples,
  hdt_stream_if.source               items,
  output hdt_cfg_t                   cfg
);

  hdt_item_t stage;
  logic      stage_valid;
  hdt_in_t   word;
  logic      take;

  // Register file writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.notch_width         <= NOTCH_WIDTH_RST;
      cfg.hysteresis_fraction <= '0;
      cfg.progressive_mode    <= 1'b0;
      cfg.start_limit         <= '0;
      cfg.end_limit           <= END_LIMIT_RST;
      cfg.vernier_factor      <= VERNIER_RST;
      cfg.sensor_ccw          <= 1'b0;
    end else if (cfg_we) begin
      unique case (hdt_reg_e'(cfg_index))
        REG_NOTCH_WIDTH: cfg.notch_width         <= cfg_data[18:0];
        REG_HYSTERESIS:  cfg.hysteresis_fraction <= cfg_data[15:0];
        REG_PROGRESSIVE: cfg.progressive_mode    <= cfg_data[0];
        REG_START_LIMIT: cfg.start_limit         <= cfg_data[15:0];
        REG_END_LIMIT:   cfg.end_limit           <= cfg_data[15:0];
        REG_VERNIER:     cfg.vernier_factor      <= cfg_data[7:0];
        REG_SENSOR_CCW:  cfg.sensor_ccw          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The stage takes a word whenever it is empty or being drained this cycle.
  assign samples.ready = !stage_valid || items.ready;
  assign take          = samples.valid && samples.ready;
  assign word          = samples.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (items.ready) begin
      stage_valid <= 1'b0;
    end
  end

  // Classify: command type, sign and magnitude of the angle.
  always_ff @(posedge clk) begin
    if (take) begin
      stage.origin <= word.command;
      stage.neg    <= word.raw_angle[31];
      stage.angle  <= word.raw_angle;
      stage.mag    <= word.raw_angle[31] ? 32'(-word.raw_angle) : word.raw_angle;
      stage.load   <= word.load_position;
    end
  end

  assign items.valid = stage_valid;
  assign items.data  = stage;

endmodule

`default_nettype wire

[src/hdt_fifo.sv]
`default_nettype none

// Short queue between the front and the back.
module hdt_fifo
  import hdt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic    clk,
  input  wire logic    rst,
  hdt_stream_if.sink   wr,
  hdt_stream_if.source rd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdt_item_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            push;
  logic            pop;

  assign wr.ready = (fill != CW'(DEPTH));
  assign rd.valid = (fill != '0);
  assign rd.data  = mem[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.data;
    end
  end

endmodule

`default_nettype wire

[src/hdt_back.sv]
`default_nettype none

// Back end: window, snap and position update, one item at a time.
module hdt_back
  import hdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire hdt_cfg_t cfg,
  hdt_stream_if.sink    items,
  hdt_stream_if.source  events
);

  hdt_state_e state;
  hdt_state_e state_next;

  hdt_item_t          item;
  logic [31:0]        amag;
  logic [MUL_P_W-1:0] mul_q;
  logic signed [31:0] attractor;
  logic signed [31:0] accepted;
  logic [15:0]        position;
  logic               at_limit;
  logic               was_at_limit;
  logic [15:0]        lim_start;
  logic [15:0]        lim_end;
  logic               out_valid;
  hdt_out_t           out_word;

  hdt_div_req_t       div_req;
  hdt_div_rsp_t       div_rsp;

  logic [18:0]        w_eff;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [31:0]        q_clamp;
  logic [23:0]        start_prod;
  logic [23:0]        end_prod;
  logic               out_free;
  logic               pop;
  logic               upd_go;

  logic [PROG_SUM_W-1:0] p_num;
  logic [31:0]           p_y;
  logic [63:0]           p_prod;
  logic [31:0]           t_mag;

  logic [MUL_P_W-1:0] h_sum;
  logic signed [33:0] h_ext;
  logic signed [33:0] t_ext;
  logic signed [33:0] a_ext;
  logic signed [33:0] ang_ext;
  logic signed [33:0] win_lo;
  logic signed [33:0] win_hi;
  logic               outside;
  logic signed [31:0] snapped;

  logic signed [31:0] attr_n;
  logic signed [31:0] acc_n;
  logic [15:0]        pos_n;
  logic               atl_n;
  logic               was_n;
  hdt_event_e         ev;
  logic               dec;

  hdt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A zero width behaves as one.
  assign w_eff    = (cfg.notch_width == '0) ? 19'd1 : cfg.notch_width;
  assign out_free = !out_valid || events.ready;

  // Quotient above 2^31 always saturates the snap, so clamp it there.
  assign q_clamp = (div_rsp.quot > DIV_NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                              : div_rsp.quot[31:0];

  // Shared multiplier operands.
  always_comb begin
    mul_a = amag;
    mul_b = MUL_B_W'(cfg.hysteresis_fraction);
    if (state == S_SMUL) begin
      mul_a = q_clamp;
      mul_b = w_eff;
    end else if (!cfg.progressive_mode) begin
      mul_a = MUL_A_W'(w_eff);
    end
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Progressive offset: 2m + D with m = 3 * |attractor| * fraction, then the
  // shift by 19 and the multiplication by the reciprocal of 5.
  assign p_num  = (PROG_SUM_W'(mul_q) << 2) + (PROG_SUM_W'(mul_q) << 1) + PROG_BIAS;
  assign p_prod = 64'(p_y) * 64'(DIV5_RECIP);

  // Scaled limits, saturated to 16 bits.
  assign start_prod = 24'(cfg.start_limit) * 24'(cfg.vernier_factor);
  assign end_prod   = 24'(cfg.end_limit) * 24'(cfg.vernier_factor);

  always_ff @(posedge clk) begin
    lim_start <= (start_prod[23:16] != '0) ? 16'hFFFF : start_prod[15:0];
    lim_end   <= (end_prod[23:16] != '0) ? 16'hFFFF : end_prod[15:0];
  end

  // Hysteresis window and the outside test.
  always_comb begin
    h_sum   = mul_q + MUL_P_W'(32768);
    h_ext   = 34'($unsigned(h_sum[35:16]));
    t_ext   = attractor[31] ? -34'($unsigned(t_mag)) : 34'($unsigned(t_mag));
    a_ext   = 34'(attractor);
    ang_ext = 34'(item.angle);
    if (cfg.progressive_mode) begin
      win_lo = a_ext + t_ext;
      win_hi = a_ext - t_ext;
    end else begin
      win_lo = a_ext - h_ext;
      win_hi = a_ext + h_ext;
    end
    outside = (ang_ext < win_lo) || (ang_ext > win_hi);
  end

  // Saturate the snapped product to the signed 32 bit range.
  always_comb begin
    if (item.neg) begin
      snapped = (mul_q >= MUL_P_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                   : -$signed(mul_q[31:0]);
    end else begin
      snapped = (mul_q > MUL_P_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                  : $signed(mul_q[31:0]);
    end
  end

  // Position counter, limits and event.
  always_comb begin
    attr_n = attractor;
    acc_n  = accepted;
    pos_n  = position;
    atl_n  = at_limit;
    was_n  = was_at_limit;
    ev     = EV_NONE;
    dec    = accepted > attractor;
    if (item.origin) begin
      attr_n = '0;
      acc_n  = '0;
      pos_n  = item.load;
    end else if (attractor != accepted) begin
      if (dec == cfg.sensor_ccw) begin
        if (position > lim_start) begin
          if (at_limit) begin
            was_n = 1'b1;
          end
          atl_n = 1'b0;
          pos_n = position - 16'd1;
          acc_n = attractor;
          ev    = EV_DECREASE;
        end else begin
          ev    = EV_NEG_LIM;
          atl_n = 1'b1;
        end
      end else begin
        if (position < lim_end) begin
          if (at_limit) begin
            was_n = 1'b1;
          end
          atl_n = 1'b0;
          pos_n = position + 16'd1;
          acc_n = attractor;
          ev    = EV_INCREASE;
        end else begin
          ev    = EV_POS_LIM;
          atl_n = 1'b1;
          if (!dec) begin
            was_n = 1'b0;
          end
        end
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (items.valid) state_next = items.data.origin ? S_UPD : S_WIN;
      S_WIN:    state_next = cfg.progressive_mode ? S_PSUM : S_CMP;
      S_PSUM:   state_next = S_PRECIP;
      S_PRECIP: state_next = S_CMP;
      S_CMP:    state_next = outside ? S_SDIV : S_UPD;
      S_SDIV:   state_next = S_SWAIT;
      S_SWAIT:  if (div_rsp.done) state_next = S_SMUL;
      S_SMUL:   state_next = S_SAT;
      S_SAT:    state_next = S_UPD;
      S_UPD:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop           = 1'b0;
    upd_go        = 1'b0;
    div_req.start = 1'b0;
    div_req.numer = (DIV_NUM_W'(item.mag) << 1) + DIV_NUM_W'(w_eff);
    div_req.denom = DIV_DEN_W'(w_eff) << 1;
    unique case (state)
      S_IDLE: pop = 1'b1;
      S_SDIV: div_req.start = 1'b1;
      S_UPD:  upd_go = out_free;
      default: ;
    endcase
  end

  assign items.ready = pop;

  // State and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      attractor    <= '0;
      accepted     <= '0;
      position     <= '0;
      at_limit     <= 1'b0;
      was_at_limit <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SAT) begin
        attractor <= snapped;
      end
      if (upd_go) begin
        attractor    <= attr_n;
        accepted     <= acc_n;
        position     <= pos_n;
        at_limit     <= atl_n;
        was_at_limit <= was_n;
        out_valid    <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    if (pop && items.valid) begin
      item <= items.data;
      amag <= attractor[31] ? 32'(-attractor) : attractor;
    end
    if (state == S_WIN || state == S_SMUL) begin
      mul_q <= mul_p;
    end
    if (state == S_PSUM) begin
      p_y <= p_num[PROG_SUM_W-1:19];
    end
    if (state == S_PRECIP) begin
      t_mag <= 32'(p_prod[63:34]);
    end
    if (upd_go) begin
      out_word.event_code        <= ev;
      out_word.position          <= pos_n;
      out_word.attract_angle_out <= attr_n;
      out_word.at_limit_flag     <= atl_n;
      out_word.was_at_limit_flag <= was_n;
    end
  end

  assign events.valid = out_valid;
  assign events.data  = out_word;

endmodule

`default_nettype wire

[src/haptic_detent_tracker.sv]
// Channel   Dir  Word       Handshake
// samples   in   hdt_in_t   valid/ready, taken when both are high
// events    out  hdt_out_t  valid/ready, taken when both are high
// cfg       in   index/data cfg_we, written on the clock edge
//
// A word in the linear window passes S_IDLE, S_WIN, S_CMP and S_UPD; a snap
// adds S_SDIV, S_SWAIT, S_SMUL and S_SAT, the progressive window S_PSUM and
// S_PRECIP. A snap waits in S_SWAIT for the iterative divider's done pulse. A
// re-origin word goes from S_IDLE to S_UPD. A result not taken holds the back
// end in its last state. Reset is synchronous and active high; it restores the
// register defaults and clears the attractors, the position and both flags.
`default_nettype none

module haptic_detent_tracker
  import hdt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  hdt_stream_if.sink                 samples,
  hdt_stream_if.source               events
);

  hdt_cfg_t cfg;

  hdt_stream_if #(.T(hdt_item_t)) front_q ();
  hdt_stream_if #(.T(hdt_item_t)) q_back ();

  // Configuration and input classification.
  hdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .items     (front_q),
    .cfg       (cfg)
  );

  // Decoupling queue.
  hdt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk (clk),
    .rst (rst),
    .wr  (front_q),
    .rd  (q_back)
  );

  // Attractor and position engine.
  hdt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .items  (q_back),
    .events (events)
  );

endmodule

`default_nettype wire
